// ===== sv/assert_macros.svh =====
// Assertion macros for the decompressor checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/lzwg_pkg.sv =====
`timescale 1ns / 1ps
package lzwg_pkg;
   localparam int WINDOW_WORDS = 1024;
   localparam int PTR_W = $clog2(WINDOW_WORDS);
   localparam int MAX_PREFIX = 23;
   localparam int ACC_W = MAX_PREFIX + 2;
   localparam int CNT_W = 31;

   localparam logic [1:0] FUNC_CONTROL = 2'd0;
   localparam logic [1:0] FUNC_LITERAL = 2'd1;

   localparam logic [1:0] ADDR_OUT_BYTES = 2'd0;

   typedef enum logic [3:0] {
      PH_FLAG, PH_LIT_PRE, PH_LIT_SUF, PH_CNT_PRE, PH_CNT_SUF,
      PH_LEN_PRE, PH_LEN_SUF, PH_OFFSET, PH_LIT_EMIT, PH_COPY
   } phase_type;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_READ, ST_DONE} seq_type;

   typedef struct packed {
      logic                 we;
      logic [PTR_W-1:0]     waddr;
      logic [31:0]          wdata;
      logic [PTR_W-1:0]     raddr;
   } ring_req_type;
endpackage

// ===== sv/lzwg_ring.sv =====
`timescale 1ns / 1ps
module lzwg_ring
   import lzwg_pkg::*;
(
   input  logic         clock,
   input  ring_req_type req,
   output logic [31:0]  rdata
);
   logic [31:0] mem_ff [WINDOW_WORDS];
   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[req.waddr] <= req.wdata;
      end
      rdata <= mem_ff[req.raddr];
   end
endmodule

// ===== sv/lz_word_gamma_decompressor_top.sv =====
`timescale 1ns / 1ps
// One transaction in gives one result transaction out. After reset the
// history ring is cleared by a sweep that writes zero to each of its 1024
// words, during which no input transaction is accepted. A transaction then
// lets the decoder consume control bits until it emits a literal, detects a
// stall, or reaches a word to be copied out of the history memory; that word
// is read through the registered read port, then written back and emitted.
// The result is then raised and held until rsp_tready, and no new input
// transaction is accepted before the result handshake.
// rsp_tdata: out_word[31:0]. rsp_tuser: out_valid, out_last, need_control,
// need_literal, bad_code, finished from bit 0 up.
module lz_word_gamma_decompressor_top
   import lzwg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // func[1:0], zero[7:2], word[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_word
   output logic [5:0]  rsp_tuser,   // out_valid,out_last,need_control,need_literal,bad_code,finished
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [31:0] out_bytes_ff;
   seq_type st_ff, st_in;
   logic [PTR_W:0] clr_ff, clr_in;
   phase_type ph_ff, ph_in;
   logic [PTR_W-1:0] wp_ff, wp_in, off_ff, off_in;
   logic [31:0] cw_ff, cw_in, lw_ff, lw_in;
   logic [4:0] pos_ff, pos_in, pc_ff, pc_in;
   logic cf_ff, cf_in, lf_ff, lf_in, err_ff, err_in;
   logic [ACC_W-1:0] acc_ff, acc_in, ml_ff, ml_in, cl_ff, cl_in;
   logic [CNT_W-1:0] we_ff, we_in;
   logic ov_ff, ov_in;
   logic [31:0] ow_ff, ow_in;
   logic rv_ff, rv_in;
   logic [31:0] rdata;
   ring_req_type rq;
   logic [32:0] target;
   logic fin, wants, need_c, need_l, b;
   logic [ACC_W-1:0] sh;

   lzwg_ring u_ring (.clock(clock), .req(rq), .rdata(rdata));

   assign csr_pready = 1'b1;
   assign csr_prdata = out_bytes_ff;
   assign target = ({1'b0, out_bytes_ff} + 33'd3) >> 2;
   assign fin = {2'b0, we_ff} >= target;
   assign wants = ph_ff <= PH_OFFSET;
   assign need_c = !err_ff && !fin && !cf_ff && wants;
   assign need_l = !err_ff && !fin && !lf_ff && ph_ff == PH_LIT_EMIT;
   assign b = cw_ff[pos_ff];
   assign sh = {acc_ff[ACC_W-2:0], b};
   assign req_tready = st_ff == ST_IDLE && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = ow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_bytes_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_OUT_BYTES) begin
         out_bytes_ff <= csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RUN; clr_ff <= '0; ph_ff <= PH_FLAG; wp_ff <= '0; off_ff <= '0;
         cw_ff <= '0; lw_ff <= '0; pos_ff <= 5'd31; pc_ff <= '0; cf_ff <= 1'b0;
         lf_ff <= 1'b0; err_ff <= 1'b0; acc_ff <= '0; ml_ff <= '0; cl_ff <= '0;
         we_ff <= '0; ov_ff <= 1'b0; ow_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; ph_ff <= ph_in; wp_ff <= wp_in; off_ff <= off_in;
         cw_ff <= cw_in; lw_ff <= lw_in; pos_ff <= pos_in; pc_ff <= pc_in; cf_ff <= cf_in;
         lf_ff <= lf_in; err_ff <= err_in; acc_ff <= acc_in; ml_ff <= ml_in; cl_ff <= cl_in;
         we_ff <= we_in; ov_ff <= ov_in;
         ow_ff <= ow_in; rv_ff <= rv_in;
      end
   end

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; ph_in = ph_ff; wp_in = wp_ff; off_in = off_ff;
      cw_in = cw_ff; lw_in = lw_ff; pos_in = pos_ff; pc_in = pc_ff; cf_in = cf_ff;
      lf_in = lf_ff; err_in = err_ff; acc_in = acc_ff; ml_in = ml_ff; cl_in = cl_ff;
      we_in = we_ff; ov_in = ov_ff; ow_in = ow_ff;
      rv_in = rv_ff && !rsp_tready;
      rq.we = 1'b0; rq.waddr = wp_ff; rq.wdata = '0;
      rq.raddr = wp_ff - off_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               ov_in = 1'b0; ow_in = '0;
               st_in = ST_DONE;
               if (req_tdata[1:0] == FUNC_CONTROL && need_c) begin
                  cw_in = req_tdata[39:8]; cf_in = 1'b1; pos_in = 5'd31;
                  st_in = ST_RUN;
               end else if (req_tdata[1:0] == FUNC_LITERAL && need_l) begin
                  lw_in = req_tdata[39:8]; lf_in = 1'b1;
                  st_in = ST_RUN;
               end else begin
                  st_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (!clr_ff[PTR_W]) begin
               rq.we = 1'b1; rq.waddr = clr_ff[PTR_W-1:0];
               clr_in = clr_ff + (PTR_W+1)'(1);
               if (clr_ff[PTR_W-1:0] == PTR_W'(WINDOW_WORDS - 1)) st_in = ST_IDLE;
            end else if (err_ff || fin || (wants && !cf_ff)) begin
               st_in = ST_DONE;
            end else begin
               if (wants) begin
                  if (pos_ff == 5'd0) begin
                     pos_in = 5'd31; cf_in = 1'b0;
                  end else begin
                     pos_in = pos_ff - 5'd1;
                  end
               end
               case (ph_ff)
                  PH_FLAG: begin
                     pc_in = '0; ph_in = b ? PH_CNT_PRE : PH_LIT_PRE;
                  end
                  PH_LIT_PRE, PH_CNT_PRE, PH_LEN_PRE: begin
                     if (b) begin
                        if (pc_ff >= 5'(MAX_PREFIX)) err_in = 1'b1;
                        else pc_in = pc_ff + 5'd1;
                     end else begin
                        acc_in = ACC_W'(1); ph_in = phase_type'(ph_ff + 4'd1);
                     end
                  end
                  PH_LIT_SUF, PH_CNT_SUF, PH_LEN_SUF: begin
                     acc_in = sh;
                     if (pc_ff == 5'd0) begin
                        case (ph_ff)
                           PH_LIT_SUF: begin
                              cl_in = sh - ACC_W'(1); ph_in = PH_LIT_EMIT;
                           end
                           PH_CNT_SUF: begin
                              ml_in = sh - ACC_W'(1); pc_in = '0; ph_in = PH_LEN_PRE;
                           end
                           default: begin
                              cl_in = sh - ACC_W'(1); acc_in = '0; pc_in = 5'd9;
                              ph_in = PH_OFFSET;
                           end
                        endcase
                     end else begin
                        pc_in = pc_ff - 5'd1;
                     end
                  end
                  PH_OFFSET: begin
                     acc_in = ACC_W'(sh[PTR_W-1:0]);
                     if (pc_ff == 5'd0) begin
                        off_in = sh[PTR_W-1:0]; ph_in = PH_COPY;
                     end else begin
                        pc_in = pc_ff - 5'd1;
                     end
                  end
                  PH_LIT_EMIT: begin
                     if (!lf_ff) begin
                        st_in = ST_DONE;
                     end else begin
                        lf_in = 1'b0;
                        rq.we = 1'b1; rq.wdata = lw_ff;
                        wp_in = wp_ff + PTR_W'(1); we_in = we_ff + CNT_W'(1);
                        ov_in = 1'b1; ow_in = lw_ff;
                        cl_in = cl_ff - ACC_W'(1);
                        if (cl_ff == ACC_W'(1)) ph_in = PH_FLAG;
                        st_in = ST_DONE;
                     end
                  end
                  PH_COPY: st_in = ST_READ;
                  default: ph_in = PH_FLAG;
               endcase
            end
         end
         ST_READ: begin
            rq.we = 1'b1; rq.wdata = rdata;
            wp_in = wp_ff + PTR_W'(1); we_in = we_ff + CNT_W'(1);
            ov_in = 1'b1; ow_in = rdata;
            cl_in = cl_ff - ACC_W'(1);
            if (cl_ff == ACC_W'(1)) begin
               ml_in = ml_ff - ACC_W'(1);
               if (ml_ff == ACC_W'(1)) ph_in = PH_FLAG;
               else begin
                  pc_in = '0; ph_in = PH_LEN_PRE;
               end
            end
            st_in = ST_DONE;
         end
         ST_DONE: begin
            rv_in = 1'b1; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp_tuser = {fin, err_ff, need_l, need_c,
                       ov_ff && ({2'b0, we_ff} == target), ov_ff};
endmodule

// ===== sv/lzwg_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lzwg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [5:0]  rsp_tuser
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `ASSERT_NEXT(a_no_accept_pending, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_NEXT(a_sticky_err, clock, reset, rsp_tvalid && rsp_tuser[4],
      !rsp_tvalid || rsp_tuser[4])
   `ASSERT_NEXT(a_last_valid, clock, reset, rsp_tvalid && rsp_tuser[1],
      $past(rsp_tuser[0]))
endmodule

bind lz_word_gamma_decompressor_top lzwg_checker u_lzwg_checker (.*);

// ===== tb/tb_lz_word_gamma_decompressor_top.sv =====
`timescale 1ns / 1ps
module tb_lz_word_gamma_decompressor_top
   import lzwg_pkg::*;
();

   localparam logic [1:0] FUNC_TICK = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 80;
   localparam int ITEM_TARGET = 850;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int errors = 0;
   int cycles = 0;
   int items_sent = 0;
   int rsp_mode = 0;

   lz_word_gamma_decompressor_top u_dut (.*);

   typedef struct packed {
      logic        out_valid;
      logic [31:0] out_word;
      logic        out_last;
      logic        need_control;
      logic        need_literal;
      logic        bad_code;
      logic        finished;
   } word_result_type;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   class decode_scoreboard;
      logic [31:0]     ring [WINDOW_WORDS];
      logic [PTR_W-1:0] wr_ptr;
      logic [31:0]     ctl_word;
      logic [4:0]      ctl_pos;
      bit              ctl_full;
      logic [31:0]     lit_word;
      bit              lit_full;
      phase_type       phase;
      int unsigned     prefix;
      int unsigned     accum;
      int unsigned     matches_left;
      int unsigned     copy_left;
      logic [9:0]      offset;
      longint unsigned emitted;
      bit              bad;
      logic [31:0]     out_bytes;
      word_result_type pending_words[$];

      function void clear();
         foreach (ring[i]) ring[i] = '0;
         wr_ptr = '0; ctl_word = '0; ctl_pos = 5'd31; ctl_full = 0;
         lit_word = '0; lit_full = 0; phase = PH_FLAG; prefix = 0; accum = 0;
         matches_left = 0; copy_left = 0; offset = '0; emitted = 0; bad = 0;
         out_bytes = '0;
      endfunction

      function longint unsigned target();
         return ({32'd0, out_bytes} + 64'd3) >> 2;
      endfunction

      function bit done();
         return emitted >= target();
      endfunction

      function bit wants_bit();
         return phase <= PH_OFFSET;
      endfunction

      function bit need_ctl();
         return !bad && !done() && !ctl_full && wants_bit();
      endfunction

      function bit need_lit();
         return !bad && !done() && !lit_full && phase == PH_LIT_EMIT;
      endfunction

      function logic take_bit();
         logic b;
         b = ctl_word[ctl_pos];
         if (ctl_pos == 0) begin
            ctl_pos = 5'd31;
            ctl_full = 0;
         end else begin
            ctl_pos--;
         end
         return b;
      endfunction

      function bit prefix_done(logic b);
         if (b) begin
            if (prefix >= MAX_PREFIX) bad = 1;
            else prefix++;
            return 0;
         end
         accum = 1;
         return 1;
      endfunction

      function bit suffix_done(logic b);
         accum = (accum << 1) | b;
         if (prefix == 0) begin
            accum = accum - 1;
            return 1;
         end
         prefix--;
         return 0;
      endfunction

      function void store_word(logic [31:0] w);
         ring[wr_ptr] = w;
         wr_ptr++;
         emitted++;
      endfunction

      function void note(logic [1:0] func, logic [31:0] word);
         word_result_type r;
         bit emit;
         bit stalled;
         logic b;
         logic [31:0] w;
         emit = 0; stalled = 0; w = '0;
         if (func == FUNC_CONTROL && need_ctl()) begin
            ctl_word = word; ctl_full = 1; ctl_pos = 5'd31;
         end else if (func == FUNC_LITERAL && need_lit()) begin
            lit_word = word; lit_full = 1;
         end
         while (!emit && !stalled && !bad && !done()) begin
            b = 0;
            if (wants_bit()) begin
               if (!ctl_full) begin
                  stalled = 1;
                  continue;
               end
               b = take_bit();
            end
            case (phase)
               PH_FLAG: begin
                  prefix = 0;
                  phase = b ? PH_CNT_PRE : PH_LIT_PRE;
               end
               PH_LIT_PRE, PH_CNT_PRE, PH_LEN_PRE: begin
                  if (prefix_done(b)) phase = phase_type'(phase + 1);
               end
               PH_LIT_SUF: begin
                  if (suffix_done(b)) begin
                     copy_left = accum;
                     phase = PH_LIT_EMIT;
                  end
               end
               PH_CNT_SUF: begin
                  if (suffix_done(b)) begin
                     matches_left = accum;
                     prefix = 0;
                     phase = PH_LEN_PRE;
                  end
               end
               PH_LEN_SUF: begin
                  if (suffix_done(b)) begin
                     copy_left = accum;
                     accum = 0;
                     prefix = 9;
                     phase = PH_OFFSET;
                  end
               end
               PH_OFFSET: begin
                  accum = ((accum << 1) | b) & 32'h3ff;
                  if (prefix == 0) begin
                     offset = accum[9:0];
                     phase = PH_COPY;
                  end else begin
                     prefix--;
                  end
               end
               PH_LIT_EMIT: begin
                  if (!lit_full) begin
                     stalled = 1;
                  end else begin
                     lit_full = 0;
                     w = lit_word;
                     store_word(w);
                     emit = 1;
                     copy_left--;
                     if (copy_left == 0) phase = PH_FLAG;
                  end
               end
               PH_COPY: begin
                  w = ring[wr_ptr - offset];
                  store_word(w);
                  emit = 1;
                  copy_left--;
                  if (copy_left == 0) begin
                     matches_left--;
                     if (matches_left == 0) begin
                        phase = PH_FLAG;
                     end else begin
                        prefix = 0;
                        phase = PH_LEN_PRE;
                     end
                  end
               end
               default: phase = PH_FLAG;
            endcase
         end
         r.out_valid = emit;
         r.out_word = emit ? w : '0;
         r.out_last = emit && emitted == target();
         r.need_control = need_ctl();
         r.need_literal = need_lit();
         r.bad_code = bad;
         r.finished = done();
         pending_words.push_back(r);
      endfunction

      task check(logic [31:0] data, logic [5:0] user);
         word_result_type e;
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected result", data, '0);
            return;
         end
         e = pending_words.pop_front();
         if (user[0] !== e.out_valid)
            report_mismatch("out_valid", 32'(user[0]), 32'(e.out_valid));
         if (data !== e.out_word) report_mismatch("out_word", data, e.out_word);
         if (user[1] !== e.out_last)
            report_mismatch("out_last", 32'(user[1]), 32'(e.out_last));
         if (user[2] !== e.need_control)
            report_mismatch("need_control", 32'(user[2]), 32'(e.need_control));
         if (user[3] !== e.need_literal)
            report_mismatch("need_literal", 32'(user[3]), 32'(e.need_literal));
         if (user[4] !== e.bad_code)
            report_mismatch("bad_code", 32'(user[4]), 32'(e.bad_code));
         if (user[5] !== e.finished)
            report_mismatch("finished", 32'(user[5]), 32'(e.finished));
      endtask
   endclass

   decode_scoreboard sb;
   bit ctl_bits[$];
   logic [31:0] lit_words[$];

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_lz_word_gamma_decompressor_top failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tuser);
      if ($urandom_range(0, 99) == 0) rsp_mode <= $urandom_range(0, 3);
      case (rsp_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 3) != 0;
         2: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= $urandom_range(0, 19) == 0;
      endcase
   end

   function automatic void push_gamma(int unsigned v);
      int n;
      int unsigned rest;
      n = 0;
      while (v >= (32'd2 << (n + 1)) - 1) n++;
      rest = v - ((32'd2 << n) - 1);
      repeat (n) ctl_bits.push_back(1'b1);
      ctl_bits.push_back(1'b0);
      for (int i = n; i >= 0; i--) ctl_bits.push_back(rest[i]);
   endfunction

   function automatic void push_record();
      int n;
      if ($urandom_range(0, 1) == 0) begin
         ctl_bits.push_back(1'b0);
         push_gamma($urandom_range(0, 9) == 0 ? $urandom_range(1, 20) : $urandom_range(1, 4));
      end else begin
         n = $urandom_range(1, 4);
         ctl_bits.push_back(1'b1);
         push_gamma(n);
         repeat (n) begin
            logic [9:0] off;
            push_gamma($urandom_range(0, 9) == 0 ? $urandom_range(1, 40)
                                                 : $urandom_range(1, 8));
            case ($urandom_range(0, 4))
               0: off = '0;
               1: off = 10'($urandom);
               default: off = 10'($urandom_range(1, 16));
            endcase
            for (int i = 9; i >= 0; i--) ctl_bits.push_back(off[i]);
         end
      end
   endfunction

   function automatic logic [31:0] next_control();
      logic [31:0] w;
      while (ctl_bits.size() < 32) push_record();
      for (int i = 31; i >= 0; i--) w[i] = ctl_bits.pop_front();
      return w;
   endfunction

   task automatic send_item(input logic [1:0] func, input logic [31:0] word);
      req_tvalid <= 1'b1;
      req_tdata <= {word, 6'd0, func};
      do @(posedge clock); while (!req_tready);
      sb.note(func, word);
      items_sent++;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         3: begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end
         default: ;
      endcase
   endtask

   task automatic send_stream_item();
      logic [1:0] f;
      if ($urandom_range(0, 11) == 0) begin
         f = 2'($urandom_range(0, 3));
         if (f == FUNC_CONTROL && sb.need_ctl()) f = FUNC_SPARE;
         send_item(f, $urandom);
      end else if (sb.need_ctl()) begin
         send_item(FUNC_CONTROL, next_control());
      end else if (sb.need_lit()) begin
         send_item(FUNC_LITERAL, lit_words.size() != 0 ? lit_words.pop_front() : $urandom);
      end else begin
         send_item(FUNC_TICK, $urandom);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_OUT_BYTES;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.out_bytes = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read_check();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_OUT_BYTES;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== sb.out_bytes) report_mismatch("out_bytes readback", csr_prdata,
                                                       sb.out_bytes);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      int budget;
      logic [31:0] size;
      logic [9:0] far_off;
      sb = new();
      sb.clear();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // size zero: finished at once, every word ignored
      send_item(FUNC_CONTROL, 32'hffffffff);
      send_item(FUNC_LITERAL, 32'h0);
      send_item(FUNC_TICK, 32'h12345678);
      send_item(FUNC_SPARE, 32'h0);
      wait_idle();
      csr_write(32'hffffffff);
      csr_read_check();
      lit_words.push_back(32'h0);
      lit_words.push_back(32'hffffffff);
      // literal run of two, then one match reaching before the first word
      far_off = 10'd5;
      ctl_bits.delete();
      ctl_bits.push_back(1'b0);
      push_gamma(2);
      ctl_bits.push_back(1'b1);
      push_gamma(1);
      push_gamma(3);
      for (int i = 9; i >= 0; i--) ctl_bits.push_back(far_off[i]);
      send_item(FUNC_LITERAL, 32'hdeadbeef);
      repeat (16) send_stream_item();
      for (int p = 0; items_sent < ITEM_TARGET; p++) begin
         budget = (p == 0) ? 150 : 120;
         while (budget > 0 && !sb.done() && items_sent < ITEM_TARGET) begin
            send_stream_item();
            budget--;
            if (p == 3 && budget == 60) begin
               req_tvalid <= 1'b0;
               while (sb.pending_words.size() != 0) @(posedge clock);
            end
         end
         send_item(FUNC_TICK, $urandom);
         wait_idle();
         case ($urandom_range(0, 5))
            0: size = 32'd0;
            1: size = 32'(sb.emitted * 4 + $urandom_range(1, 4));
            2: size = 32'hffffffff;
            default: size = 32'(sb.emitted * 4 + $urandom_range(5, 300));
         endcase
         csr_write(size);
      end
      wait_idle();
      csr_write(32'hffffffff);
      // runs of ones beyond the longest prefix raise the sticky error
      for (int i = 0; i < 40 && !sb.bad; i++) begin
         if (sb.need_ctl()) send_item(FUNC_CONTROL, 32'hffffffff);
         else if (sb.need_lit()) send_item(FUNC_LITERAL, $urandom);
         else send_item(FUNC_TICK, $urandom);
      end
      send_item(FUNC_CONTROL, 32'h0);
      send_item(FUNC_LITERAL, $urandom);
      send_item(FUNC_TICK, $urandom);
      wait_idle();
      if (errors == 0 && sb.pending_words.size() == 0) begin
         $display("tb_lz_word_gamma_decompressor_top passed");
      end else begin
         $display("tb_lz_word_gamma_decompressor_top failed");
      end
      $finish;
   end
endmodule
